### hw/rtl/tpm_pkg.sv
// Shared constants and control types for the temporal pixel median block.
`default_nettype none

package tpm_pkg;

  localparam int DATA_W         = 8;
  localparam int BIT_IDX_W      = 3;
  localparam int MAX_FRAMES_DEF = 16;

  // Sequencer to channel selector controls
  typedef struct packed {
    logic                 start;    // latch rank, clear answer and zero count
    logic                 rd_en;    // read store entry at rd_addr
    logic                 acc;      // read data valid, count zero bits
    logic                 decide;   // settle one answer bit
    logic [BIT_IDX_W-1:0] bit_idx;  // bit plane under test
  } tpm_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/tpm_chan_select.sv
// One channel: sample store and bit-serial rank selection, MSB first.
`default_nettype none

module tpm_chan_select #(
  parameter int MAX_FRAMES = tpm_pkg::MAX_FRAMES_DEF,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1),
  parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_addr,
  input  wire logic [tpm_pkg::DATA_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]           rd_addr,
  input  wire tpm_pkg::tpm_ctrl_t         ctrl,
  input  wire logic [CNT_W-1:0]           rank,
  output logic      [tpm_pkg::DATA_W-1:0] median
);
  import tpm_pkg::*;

  logic [DATA_W-1:0] mem [MAX_FRAMES];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] ans;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  zcnt;
  logic [DATA_W-1:0] hi_mask;
  logic              cand_zero;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entry is still a candidate when its bits above the plane match the answer so far
  always_comb begin
    for (int j = 0; j < DATA_W; j++) begin
      hi_mask[j] = (j > int'(ctrl.bit_idx));
    end
    cand_zero = (((rd_data ^ ans) & hi_mask) == '0) && !rd_data[ctrl.bit_idx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      ans  <= '0;
      k    <= rank;
      zcnt <= '0;
    end else if (ctrl.decide) begin
      zcnt <= '0;
      if (zcnt <= k) begin
        ans[ctrl.bit_idx] <= 1'b1;
        k                 <= k - zcnt;
      end
    end else if (ctrl.acc && cand_zero) begin
      zcnt <= zcnt + CNT_W'(1);
    end
  end

  assign median = ans;

endmodule

`default_nettype wire

### hw/rtl/temporal_pixel_median_core.sv
// Temporal median core: per-pixel sample stores and a bit-serial median sequencer.
// Unflagged items: one transfer per cycle while in_ready is high, stored, no result.
// Flagged item: starts a median over N = samples held (<= MAX_FRAMES) by eight
//   bit-plane sweeps, each of N store reads (shared read port), a drain and a decide
//   state, then the output register load. Samples beyond a full store are dropped.
// Input is held off (in_ready low) from the flagged transfer until the result is loaded,
//   longer if the previous result still waits; a loaded result may wait in the output
//   register while the next pixel's samples stream in.
// Reset (rst, synchronous): count, overflow flag, sequencer and out_valid cleared;
//   store contents are left undefined.
`default_nettype none

module temporal_pixel_median_core #(
  parameter int MAX_FRAMES = tpm_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tpm_pkg::DATA_W-1:0] sample_first,
  input  wire logic [tpm_pkg::DATA_W-1:0] sample_second,
  input  wire logic [tpm_pkg::DATA_W-1:0] sample_third,
  input  wire logic                       last_frame,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [tpm_pkg::DATA_W-1:0] median_first,
  output logic      [tpm_pkg::DATA_W-1:0] median_second,
  output logic      [tpm_pkg::DATA_W-1:0] median_third,
  output logic                            overflowed
);
  import tpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     frames_held;
  logic                 overflow_seen;
  logic [CNT_W-1:0]     sel_count;     // samples taking part in this median
  logic [IDX_W-1:0]     idx;           // sweep read address
  logic [BIT_IDX_W-1:0] bit_idx;       // current bit plane, MSB first
  logic                 acc;           // read data from the sweep is valid

  logic                 in_xfer;
  logic                 store_full;
  logic [CNT_W-1:0]     count_next;
  logic                 sweep_last;
  logic                 out_free;
  tpm_ctrl_t            ctrl;

  logic [DATA_W-1:0]    med_a;
  logic [DATA_W-1:0]    med_b;
  logic [DATA_W-1:0]    med_c;

  assign in_ready   = (state == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign store_full = (frames_held == CNT_W'(MAX_FRAMES));
  assign count_next = store_full ? frames_held : frames_held + CNT_W'(1);
  assign sweep_last = ((CNT_W'(idx) + CNT_W'(1)) == sel_count);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    ctrl.start   = in_xfer && last_frame;
    ctrl.rd_en   = (state == ST_SWEEP);
    ctrl.acc     = acc;
    ctrl.decide  = (state == ST_DECIDE);
    ctrl.bit_idx = bit_idx;
  end

  // the three channels share one write and one read address
  tpm_chan_select #(.MAX_FRAMES(MAX_FRAMES), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_sel_first (
    .clk     (clk),
    .wr_en   (in_xfer && !store_full),
    .wr_addr (frames_held[IDX_W-1:0]),
    .wr_data (sample_first),
    .rd_addr (idx),
    .ctrl    (ctrl),
    .rank    (count_next >> 1),
    .median  (med_a)
  );

  tpm_chan_select #(.MAX_FRAMES(MAX_FRAMES), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_sel_second (
    .clk     (clk),
    .wr_en   (in_xfer && !store_full),
    .wr_addr (frames_held[IDX_W-1:0]),
    .wr_data (sample_second),
    .rd_addr (idx),
    .ctrl    (ctrl),
    .rank    (count_next >> 1),
    .median  (med_b)
  );

  tpm_chan_select #(.MAX_FRAMES(MAX_FRAMES), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_sel_third (
    .clk     (clk),
    .wr_en   (in_xfer && !store_full),
    .wr_addr (frames_held[IDX_W-1:0]),
    .wr_data (sample_third),
    .rd_addr (idx),
    .ctrl    (ctrl),
    .rank    (count_next >> 1),
    .median  (med_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_held   <= '0;
      overflow_seen <= 1'b0;
      sel_count     <= '0;
      idx           <= '0;
      bit_idx       <= '0;
      acc           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      acc <= (state == ST_SWEEP);
      // a new result takes the register as the old one leaves
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            // a full store drops the sample and flags it
            if (store_full) begin
              overflow_seen <= 1'b1;
            end
            frames_held <= count_next;
            if (last_frame) begin
              sel_count <= count_next;
              idx       <= '0;
              bit_idx   <= BIT_IDX_W'(DATA_W - 1);
              state     <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (sweep_last) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          idx <= '0;
          if (bit_idx == '0) begin
            state <= ST_DONE;
          end else begin
            bit_idx <= bit_idx - BIT_IDX_W'(1);
            state   <= ST_SWEEP;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            median_first  <= med_a;
            median_second <= med_b;
            median_third  <= med_c;
            overflowed    <= overflow_seen;
            frames_held   <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frames_held <= CNT_W'(MAX_FRAMES))
    else $error("sample count beyond store depth");

  // a flagged transfer stops further input at once
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_frame |=> !in_ready)
    else $error("input still open after flagged transfer");

  // a new result only appears from the completion step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

  // delivering a result clears the pixel state
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> (frames_held == '0) && !overflow_seen && in_ready)
    else $error("pixel state not cleared after result");

endmodule

`default_nettype wire
